[src/swmss_pkg.sv]
// Shared widths, types and step counts for the sliding window statistics block.
package swmss_pkg;

    // Widths sized for the largest window of 256 samples.
    localparam int CNT_W  = 9;
    localparam int S1_W   = 24;
    localparam int S2_W   = 39;
    localparam int S3_W   = 54;
    localparam int NN_W   = 16;
    localparam int WIDE_W = 192;
    localparam int MB_W   = 80;
    localparam int Q_W    = 48;
    localparam int K_W    = 6;

    // Quotient bit positions, root steps and skewness scaling of the shared unit.
    localparam int DIV_MN_K  = 23;
    localparam int DIV_SD_K  = 47;
    localparam int DIV_SK_K  = 30;
    localparam int SQRT_K    = 23;
    localparam int SQRT_TOP  = 46;
    localparam int SKEW_SH   = 24;
    localparam int SKEW_CAP  = 30;

    typedef logic [WIDE_W-1:0] t_wide;
    typedef logic [MB_W-1:0]   t_mb;

endpackage

[src/swmss_ram.sv]
// Generic single write port RAM with a registered read port.
module swmss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sliding_window_mean_std_skew.sv]
// Sliding window mean, sample standard deviation and adjusted skewness.
//
// Input channel: i_valid, i_sample (signed Q8.8) and o_stall. A word is taken
// at a rising edge with i_valid high and o_stall low. Output channel: o_valid,
// o_mean, o_std_dev, o_skewness, o_window_full, o_fill_count and i_stall.
// Every input word gives exactly one output word.
// The last WINDOW samples sit in a RAM ring; exact integer sums of samples,
// squares and cubes are kept. All products, the three divisions and the two
// square roots run on one shared shift-add, shift-subtract datapath under a
// sequencer. The divisions give quotients of 24, 48 and 31 bits, and the time
// to a result depends on the fill and on the operand magnitudes. A new word
// is taken only after the result word of the last one has been taken, when
// the block is back in idle. o_stall is high from the cycle after acceptance
// until the result has been taken.
// When the receiver stalls, the result word is held and no new word is taken.
// Reset (synchronous, active low) empties the window and clears the sums; the
// block is ready in the first cycle after reset.
module sliding_window_mean_std_skew #(
    parameter int WINDOW = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_mean,
    output logic        [15:0] o_std_dev,
    output logic signed [15:0] o_skewness,
    output logic               o_window_full,
    output logic        [5:0]  o_fill_count
);

    localparam int AW    = $clog2(WINDOW);
    localparam int W     = swmss_pkg::WIDE_W;
    localparam int MB    = swmss_pkg::MB_W;
    localparam int QW    = swmss_pkg::Q_W;
    localparam int CW    = swmss_pkg::CNT_W;
    localparam int KW    = swmss_pkg::K_W;
    localparam int S1W   = swmss_pkg::S1_W;
    localparam int S2W   = swmss_pkg::S2_W;
    localparam int S3W   = swmss_pkg::S3_W;
    localparam int NNW   = swmss_pkg::NN_W;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_LOAD  = 5'd1;
    localparam logic [4:0] ST_X2    = 5'd2;
    localparam logic [4:0] ST_O2    = 5'd3;
    localparam logic [4:0] ST_X3    = 5'd4;
    localparam logic [4:0] ST_O3    = 5'd5;
    localparam logic [4:0] ST_S1SQ  = 5'd6;
    localparam logic [4:0] ST_DVAR  = 5'd7;
    localparam logic [4:0] ST_NN1   = 5'd8;
    localparam logic [4:0] ST_DIVMN = 5'd9;
    localparam logic [4:0] ST_DIVSD = 5'd10;
    localparam logic [4:0] ST_SQSD  = 5'd11;
    localparam logic [4:0] ST_T1    = 5'd12;
    localparam logic [4:0] ST_T2    = 5'd13;
    localparam logic [4:0] ST_T3    = 5'd14;
    localparam logic [4:0] ST_T4    = 5'd15;
    localparam logic [4:0] ST_M1    = 5'd16;
    localparam logic [4:0] ST_M2    = 5'd17;
    localparam logic [4:0] ST_M3    = 5'd18;
    localparam logic [4:0] ST_M4    = 5'd19;
    localparam logic [4:0] ST_N1    = 5'd20;
    localparam logic [4:0] ST_N2    = 5'd21;
    localparam logic [4:0] ST_DIVSK = 5'd22;
    localparam logic [4:0] ST_SQSK  = 5'd23;
    localparam logic [4:0] ST_OUT   = 5'd24;

    localparam logic [CW-1:0] CNT_FULL = CW'(WINDOW);
    localparam logic [CW-1:0] CNT_TWO  = CW'(2);
    localparam logic [CW-1:0] CNT_THREE = CW'(3);

    // Control state and window sums
    logic [4:0]            r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [AW-1:0]         r_wpos, n_wpos;
    logic signed [S1W-1:0] r_s1, n_s1;
    logic [S2W-1:0]        r_s2, n_s2;
    logic signed [S3W-1:0] r_s3, n_s3;

    // Datapath and result registers
    logic signed [15:0]    r_x, n_x;
    logic signed [15:0]    r_old, n_old;
    logic                  r_drop, n_drop;
    swmss_pkg::t_wide      r_acc, n_acc;
    swmss_pkg::t_wide      r_ra, n_ra;
    swmss_pkg::t_mb        r_rb, n_rb;
    swmss_pkg::t_wide      r_rt, n_rt;
    swmss_pkg::t_wide      r_rtt, n_rtt;
    logic [QW-1:0]         r_q, n_q;
    logic [KW-1:0]         r_k, n_k;
    logic [QW-1:0]         r_s1sq, n_s1sq;
    logic [QW-1:0]         r_d, n_d;
    logic [NNW-1:0]        r_nn1, n_nn1;
    logic                  r_neg, n_neg;
    logic signed [15:0]    r_mean, n_mean;
    logic [15:0]           r_sd, n_sd;
    logic signed [15:0]    r_sk, n_sk;

    logic [15:0]           ram_rdata;
    logic                  ram_we;
    logic [16:0]           x_mag;
    logic [16:0]           old_mag;
    logic [S1W:0]          s1_mag;
    logic                  load_drop;
    swmss_pkg::t_wide      mul_acc;
    logic                  div_ge;
    swmss_pkg::t_wide      div_acc;
    logic [QW-1:0]         div_q;
    swmss_pkg::t_wide      sq_sum;
    logic                  sq_ge;
    swmss_pkg::t_wide      sq_acc;
    swmss_pkg::t_wide      sq_root;
    logic [QW-1:0]         sk_arg;

    swmss_ram #(
        .WIDTH (16),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos),
        .i_wdata (r_x),
        .i_raddr (r_wpos),
        .o_rdata (ram_rdata)
    );

    assign ram_we    = (r_state == ST_LOAD);
    assign load_drop = (r_cnt == CNT_FULL);

    assign x_mag   = r_x[15] ? (17'd0 - 17'(r_x)) : 17'(r_x);
    assign old_mag = r_old[15] ? (17'd0 - 17'(r_old)) : 17'(r_old);
    assign s1_mag  = r_s1[S1W-1] ? ((S1W+1)'(0) - (S1W+1)'(r_s1)) : (S1W+1)'(r_s1);

    // Shared unit: one shift-add, shift-subtract or root step per cycle.
    assign mul_acc = r_acc + (r_rb[0] ? r_ra : W'(0));
    assign div_ge  = (r_acc >= r_ra);
    assign div_acc = div_ge ? (r_acc - r_ra) : r_acc;
    assign div_q   = {r_q[QW-2:0], div_ge};
    assign sq_sum  = r_ra + W'(r_rb);
    assign sq_ge   = (r_acc >= sq_sum);
    assign sq_acc  = sq_ge ? (r_acc - sq_sum) : r_acc;
    assign sq_root = sq_ge ? ((r_ra >> 1) + W'(r_rb)) : (r_ra >> 1);
    assign sk_arg  = (div_q > (QW'(1) << swmss_pkg::SKEW_CAP))
                   ? (QW'(1) << swmss_pkg::SKEW_CAP) : div_q;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_wpos  = r_wpos;
        n_s1    = r_s1;
        n_s2    = r_s2;
        n_s3    = r_s3;
        n_x     = r_x;
        n_old   = r_old;
        n_drop  = r_drop;
        n_acc   = r_acc;
        n_ra    = r_ra;
        n_rb    = r_rb;
        n_rt    = r_rt;
        n_rtt   = r_rtt;
        n_q     = r_q;
        n_k     = r_k;
        n_s1sq  = r_s1sq;
        n_d     = r_d;
        n_nn1   = r_nn1;
        n_neg   = r_neg;
        n_mean  = r_mean;
        n_sd    = r_sd;
        n_sk    = r_sk;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_x     = i_sample;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // The oldest sample leaves the sums only once the ring is full.
                n_drop  = load_drop;
                n_old   = ram_rdata;
                n_cnt   = load_drop ? r_cnt : r_cnt + CW'(1);
                n_wpos  = (r_wpos == AW'(WINDOW - 1)) ? AW'(0) : r_wpos + AW'(1);
                n_s1    = r_s1 + S1W'(r_x) - (load_drop ? S1W'($signed(ram_rdata)) : S1W'(0));
                n_acc   = W'(0);
                n_ra    = W'(x_mag);
                n_rb    = MB'(x_mag);
                n_state = ST_X2;
            end
            ST_X2: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_rt    = r_acc;
                    n_acc   = W'(0);
                    n_ra    = W'(old_mag);
                    n_rb    = r_drop ? MB'(old_mag) : MB'(0);
                    n_state = ST_O2;
                end
            end
            ST_O2: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_rtt   = r_acc;
                    n_s2    = r_s2 + S2W'(r_rt) - S2W'(r_acc);
                    n_acc   = W'(r_s3);
                    n_ra    = W'(r_x);
                    n_rb    = r_rt[MB-1:0];
                    n_state = ST_X3;
                end
            end
            ST_X3: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_ra    = W'(0) - W'(r_old);
                    n_rb    = r_drop ? r_rtt[MB-1:0] : MB'(0);
                    n_state = ST_O3;
                end
            end
            ST_O3: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_s3    = r_acc[S3W-1:0];
                    n_acc   = W'(0);
                    n_ra    = W'(s1_mag);
                    n_rb    = MB'(s1_mag);
                    n_state = ST_S1SQ;
                end
            end
            ST_S1SQ: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_s1sq  = r_acc[QW-1:0];
                    n_acc   = W'(0) - r_acc;
                    n_ra    = W'(r_s2);
                    n_rb    = MB'(r_cnt);
                    n_state = ST_DVAR;
                end
            end
            ST_DVAR: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_d     = r_acc[QW-1:0];
                    n_acc   = W'(0);
                    n_ra    = W'(r_cnt);
                    n_rb    = MB'(r_cnt - CW'(1));
                    n_state = ST_NN1;
                end
            end
            ST_NN1: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_nn1   = r_acc[NNW-1:0];
                    n_acc   = W'(s1_mag);
                    n_ra    = W'(r_cnt) << swmss_pkg::DIV_MN_K;
                    n_q     = QW'(0);
                    n_k     = KW'(swmss_pkg::DIV_MN_K);
                    n_state = ST_DIVMN;
                end
            end
            ST_DIVMN: begin
                n_acc = div_acc;
                n_q   = div_q;
                n_ra  = r_ra >> 1;
                n_k   = r_k - KW'(1);
                if (r_k == KW'(0)) begin
                    // Truncation toward zero: divide the magnitude, then restore the sign.
                    n_mean = r_s1[S1W-1] ? (16'd0 - div_q[15:0]) : div_q[15:0];
                    if (r_cnt < CNT_TWO) begin
                        n_sd    = 16'd0;
                        n_sk    = 16'sd0;
                        n_state = ST_OUT;
                    end else begin
                        n_acc   = W'(r_d);
                        n_ra    = W'(r_nn1) << swmss_pkg::DIV_SD_K;
                        n_q     = QW'(0);
                        n_k     = KW'(swmss_pkg::DIV_SD_K);
                        n_state = ST_DIVSD;
                    end
                end
            end
            ST_DIVSD: begin
                n_acc = div_acc;
                n_q   = div_q;
                n_ra  = r_ra >> 1;
                n_k   = r_k - KW'(1);
                if (r_k == KW'(0)) begin
                    n_acc   = W'(div_q);
                    n_ra    = W'(0);
                    n_rb    = MB'(1) << swmss_pkg::SQRT_TOP;
                    n_k     = KW'(swmss_pkg::SQRT_K);
                    n_state = ST_SQSD;
                end
            end
            ST_SQSD: begin
                n_acc = sq_acc;
                n_ra  = sq_root;
                n_rb  = r_rb >> 2;
                n_k   = r_k - KW'(1);
                if (r_k == KW'(0)) begin
                    n_sd = (sq_root > W'(16'hffff)) ? 16'hffff : sq_root[15:0];
                    if ((r_cnt < CNT_THREE) || (r_d == QW'(0))) begin
                        n_sk    = 16'sd0;
                        n_state = ST_OUT;
                    end else begin
                        n_acc   = W'(0);
                        n_ra    = W'(r_s1);
                        n_rb    = MB'(r_s2);
                        n_state = ST_T1;
                    end
                end
            end
            ST_T1: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_acc   = W'(0);
                    n_ra    = W'(0) - r_acc;
                    n_rb    = MB'(r_cnt) + (MB'(r_cnt) << 1);
                    n_state = ST_T2;
                end
            end
            ST_T2: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_ra    = W'(r_s3);
                    n_rb    = MB'(r_nn1) + MB'(r_cnt);
                    n_state = ST_T3;
                end
            end
            ST_T3: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_ra    = W'(r_s1) << 1;
                    n_rb    = MB'(r_s1sq);
                    n_state = ST_T4;
                end
            end
            ST_T4: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_neg   = r_acc[W-1];
                    n_rtt   = r_acc[W-1] ? (W'(0) - r_acc) : r_acc;
                    n_acc   = W'(0);
                    n_ra    = W'(r_d);
                    n_rb    = MB'(r_d);
                    n_state = ST_M1;
                end
            end
            ST_M1: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_acc   = W'(0);
                    n_ra    = r_acc;
                    n_rb    = MB'(r_d);
                    n_state = ST_M2;
                end
            end
            ST_M2: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_acc   = W'(0);
                    n_ra    = r_acc;
                    n_rb    = MB'(r_cnt - CNT_TWO);
                    n_state = ST_M3;
                end
            end
            ST_M3: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_acc   = W'(0);
                    n_ra    = r_acc;
                    n_rb    = MB'(r_cnt - CNT_TWO);
                    n_state = ST_M4;
                end
            end
            ST_M4: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_rt    = r_acc;
                    n_acc   = W'(0);
                    n_ra    = r_rtt;
                    n_rb    = r_rtt[MB-1:0];
                    n_state = ST_N1;
                end
            end
            ST_N1: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    n_acc   = W'(0);
                    n_ra    = r_acc << swmss_pkg::SKEW_SH;
                    n_rb    = MB'(r_nn1);
                    n_state = ST_N2;
                end
            end
            ST_N2: begin
                if (r_rb != MB'(0)) begin
                    n_acc = mul_acc;
                    n_ra  = r_ra << 1;
                    n_rb  = r_rb >> 1;
                end else begin
                    // The accumulator now holds the numerator and stays as the remainder.
                    n_ra    = r_rt << swmss_pkg::DIV_SK_K;
                    n_q     = QW'(0);
                    n_k     = KW'(swmss_pkg::DIV_SK_K);
                    n_state = ST_DIVSK;
                end
            end
            ST_DIVSK: begin
                n_acc = div_acc;
                n_q   = div_q;
                n_ra  = r_ra >> 1;
                n_k   = r_k - KW'(1);
                if (r_k == KW'(0)) begin
                    // An oversized quotient comes out as all ones and is capped here.
                    n_acc   = W'(sk_arg);
                    n_ra    = W'(0);
                    n_rb    = MB'(1) << swmss_pkg::SQRT_TOP;
                    n_k     = KW'(swmss_pkg::SQRT_K);
                    n_state = ST_SQSK;
                end
            end
            ST_SQSK: begin
                n_acc = sq_acc;
                n_ra  = sq_root;
                n_rb  = r_rb >> 2;
                n_k   = r_k - KW'(1);
                if (r_k == KW'(0)) begin
                    if (r_neg) begin
                        n_sk = 16'd0 - sq_root[15:0];
                    end else begin
                        n_sk = (sq_root > W'(16'h7fff)) ? 16'sh7fff : sq_root[15:0];
                    end
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_wpos  <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_s3    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wpos  <= n_wpos;
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_s3    <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_old  <= n_old;
        r_drop <= n_drop;
        r_acc  <= n_acc;
        r_ra   <= n_ra;
        r_rb   <= n_rb;
        r_rt   <= n_rt;
        r_rtt  <= n_rtt;
        r_q    <= n_q;
        r_k    <= n_k;
        r_s1sq <= n_s1sq;
        r_d    <= n_d;
        r_nn1  <= n_nn1;
        r_neg  <= n_neg;
        r_mean <= n_mean;
        r_sd   <= n_sd;
        r_sk   <= n_sk;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_OUT);
    assign o_mean        = r_mean;
    assign o_std_dev     = r_sd;
    assign o_skewness    = r_sk;
    assign o_window_full = (r_cnt == CNT_FULL);
    assign o_fill_count  = r_cnt[5:0];

    // A new word is never taken while a result word is still on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !o_valid)
        else $error("input word taken while a result word is pending");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((r_cnt != CW'(0)) && (r_cnt <= CNT_FULL)))
        else $error("fill count out of range with a result on offer");

    a_short_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_cnt < CNT_TWO)) |-> ((o_std_dev == 16'd0) && (o_skewness == 16'sd0)))
        else $error("statistics not zero for a single sample");

endmodule
